[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define VSPM_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// Expression that must never be true outside reset.
`define VSPM_ASSERT_NEVER(label, clk, rstn, expr) \
  label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("forbidden condition seen");

`endif

[rtl/core/vspm_pkg.sv]
// Types and constants of the voltage spread plausibility monitor.
package vspm_pkg;

  localparam int unsigned VoltW   = 20;
  localparam int unsigned IdxW    = 2;
  localparam int unsigned ModeW   = 3;
  localparam int unsigned EventW  = 2;
  localparam int unsigned SeenW   = 3;
  localparam int unsigned ThreshW = 20;
  localparam int unsigned TicksW  = 16;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned MinSeen = 2;

  localparam logic [ThreshW-1:0] ThreshReset = 20'd5000;
  localparam logic [TicksW-1:0]  TicksReset  = 16'd1000;

  typedef enum logic [ModeW-1:0] {
    MODE_SAMPLE = 3'd0,
    MODE_TICK   = 3'd1,
    MODE_START  = 3'd2,
    MODE_STOP   = 3'd3,
    MODE_RESET  = 3'd4
  } mode_e;

  typedef enum logic [EventW-1:0] {
    EV_NONE      = 2'd0,
    EV_IMMEDIATE = 2'd1,
    EV_TIMER     = 2'd2
  } event_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_THRESHOLD = 1'b0,
    CFG_TICKS     = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [ModeW-1:0]        mode;
    logic [IdxW-1:0]         source_index;
    logic signed [VoltW-1:0] sample_voltage;
  } req_t;

  typedef struct packed {
    logic                fault_latched;
    logic [EventW-1:0]   fault_event;
    logic [VoltW-1:0]    spread_value;
    logic                timer_running;
    logic                monitor_running;
    logic [SeenW-1:0]    seen_count;
  } rsp_t;

  typedef struct packed {
    logic [ThreshW-1:0] threshold;
    logic [TicksW-1:0]  ticks;
  } cfg_t;

endpackage

[rtl/core/vspm_req_if.sv]
// Request channel: valid/ready handshake with one monitor request.
interface vspm_req_if;
  import vspm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [ModeW-1:0]        mode;
  logic [IdxW-1:0]         source_index;
  logic signed [VoltW-1:0] sample_voltage;

  modport source (output valid, output mode, output source_index, output sample_voltage,
                  input ready);
  modport sink (input valid, input mode, input source_index, input sample_voltage,
                output ready);
endinterface

[rtl/core/vspm_rsp_if.sv]
// Result channel: valid/ready handshake with one monitor status.
interface vspm_rsp_if;
  import vspm_pkg::*;

  logic              valid;
  logic              ready;
  logic              fault_latched;
  logic [EventW-1:0] fault_event;
  logic [VoltW-1:0]  spread_value;
  logic              timer_running;
  logic              monitor_running;
  logic [SeenW-1:0]  seen_count;

  modport source (output valid, output fault_latched, output fault_event,
                  output spread_value, output timer_running, output monitor_running,
                  output seen_count, input ready);
  modport sink (input valid, input fault_latched, input fault_event,
                input spread_value, input timer_running, input monitor_running,
                input seen_count, output ready);
endinterface

[rtl/core/vspm_spread.sv]
// Max minus min over the seen sources (zero when fewer than two are seen), and the count of seen sources.
module vspm_spread #(
  parameter int unsigned NUM_SOURCES = 4,
  localparam int unsigned CntW = $clog2(NUM_SOURCES + 1)
) (
  input  logic signed [vspm_pkg::VoltW-1:0] vals_i [NUM_SOURCES],
  input  logic [NUM_SOURCES-1:0]            seen_i,
  output logic [vspm_pkg::VoltW-1:0]        spread_o,
  output logic [CntW-1:0]                   count_o
);
  import vspm_pkg::*;

  localparam logic signed [VoltW-1:0] VMax = {1'b0, {(VoltW-1){1'b1}}};
  localparam logic signed [VoltW-1:0] VMin = {1'b1, {(VoltW-1){1'b0}}};

  logic signed [VoltW-1:0] lo;
  logic signed [VoltW-1:0] hi;
  logic signed [VoltW:0]   diff;
  logic [CntW-1:0]         cnt;

  always_comb begin
    lo  = VMax;
    hi  = VMin;
    cnt = '0;
    for (int i = 0; i < NUM_SOURCES; i++) begin
      if (seen_i[i]) begin
        cnt = cnt + CntW'(1);
        if (vals_i[i] < lo) begin
          lo = vals_i[i];
        end
        if (vals_i[i] > hi) begin
          hi = vals_i[i];
        end
      end
    end
    diff = (VoltW+1)'(hi) - (VoltW+1)'(lo);
  end

  assign count_o  = cnt;
  assign spread_o = (32'(cnt) >= MinSeen) ? diff[VoltW-1:0] : '0;

endmodule

[rtl/core/vspm_state.sv]
// Monitor state registers and the per-request update of flags, timer and sources.
module vspm_state #(
  parameter int unsigned NUM_SOURCES = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           commit_i,
  input  vspm_pkg::req_t req_i,
  input  vspm_pkg::cfg_t cfg_i,
  output vspm_pkg::rsp_t rsp_o
);
  import vspm_pkg::*;

  localparam int unsigned CntW = $clog2(NUM_SOURCES + 1);

  logic signed [VoltW-1:0] vals_q [NUM_SOURCES];
  logic signed [VoltW-1:0] vals_d [NUM_SOURCES];
  logic [NUM_SOURCES-1:0]  seen_q, seen_d;
  logic                    run_q, run_d;
  logic                    latch_q, latch_d;
  logic                    armed_q, armed_d;
  logic [TicksW-1:0]       elapsed_q, elapsed_d;

  logic [VoltW-1:0]  spread;
  logic [CntW-1:0]   cnt;
  logic              sample_ok;
  logic              idx_hit;
  logic              enough;
  logic              over;
  logic [TicksW-1:0] tick_inc;
  event_e            ev;
  mode_e             mode;

  assign mode      = mode_e'(req_i.mode);
  assign sample_ok = (mode == MODE_SAMPLE) && run_q && !latch_q;

  always_comb begin
    vals_d  = vals_q;
    seen_d  = seen_q;
    idx_hit = 1'b0;
    for (int i = 0; i < NUM_SOURCES; i++) begin
      if (32'(req_i.source_index) == i) begin
        idx_hit = 1'b1;
        if (sample_ok) begin
          vals_d[i] = req_i.sample_voltage;
          seen_d[i] = 1'b1;
        end
      end
    end
    if (mode == MODE_RESET) begin
      seen_d = '0;
    end
  end

  vspm_spread #(
    .NUM_SOURCES(NUM_SOURCES)
  ) u_vspm_spread (
    .vals_i  (vals_d),
    .seen_i  (seen_d),
    .spread_o(spread),
    .count_o (cnt)
  );

  assign enough   = 32'(cnt) >= MinSeen;
  assign over     = spread > cfg_i.threshold;
  assign tick_inc = (elapsed_q != '1) ? elapsed_q + TicksW'(1) : elapsed_q;

  always_comb begin
    run_d     = run_q;
    latch_d   = latch_q;
    armed_d   = armed_q;
    elapsed_d = elapsed_q;
    ev        = EV_NONE;
    unique case (mode)
      MODE_SAMPLE: begin
        if (sample_ok && idx_hit) begin
          if (!enough) begin
            armed_d = 1'b0;
          end else if (over) begin
            if (cfg_i.ticks == '0) begin
              latch_d = 1'b1;
              run_d   = 1'b0;
              armed_d = 1'b0;
              ev      = EV_IMMEDIATE;
            end else if (!armed_q) begin
              armed_d   = 1'b1;
              elapsed_d = '0;
            end
          end else begin
            armed_d = 1'b0;
          end
        end
      end
      MODE_TICK: begin
        if (armed_q) begin
          elapsed_d = tick_inc;
          if (tick_inc >= cfg_i.ticks) begin
            armed_d = 1'b0;
            if (run_q && !latch_q && enough && over) begin
              latch_d = 1'b1;
              run_d   = 1'b0;
              ev      = EV_TIMER;
            end
          end
        end
      end
      MODE_START: begin
        latch_d = 1'b0;
        armed_d = 1'b0;
        run_d   = 1'b1;
      end
      MODE_STOP: begin
        run_d   = 1'b0;
        armed_d = 1'b0;
      end
      MODE_RESET: begin
        latch_d = 1'b0;
        armed_d = 1'b0;
      end
      default: ;
    endcase
  end

  always_comb begin
    rsp_o.fault_latched   = latch_d;
    rsp_o.fault_event     = ev;
    rsp_o.spread_value    = spread;
    rsp_o.timer_running   = armed_d;
    rsp_o.monitor_running = run_d;
    rsp_o.seen_count      = (32'(cnt) > 32'd7) ? 3'd7 : SeenW'(cnt);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q    <= '0;
      run_q     <= 1'b0;
      latch_q   <= 1'b0;
      armed_q   <= 1'b0;
      elapsed_q <= '0;
    end else if (commit_i) begin
      seen_q    <= seen_d;
      run_q     <= run_d;
      latch_q   <= latch_d;
      armed_q   <= armed_d;
      elapsed_q <= elapsed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit_i) begin
      vals_q <= vals_d;
    end
  end

endmodule

[rtl/core/voltage_spread_plausibility_monitor.sv]
// Top level of the voltage spread plausibility monitor.
// A request is captured in the input register, then its result in the result register, which offers it.
// Throughput: one request per cycle while results are taken; the input and result registers each hold one.
// Reset: clears flags, seen marks, timer and handshake state; restores register defaults.
module voltage_spread_plausibility_monitor #(
  parameter int unsigned NUM_SOURCES = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [vspm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [vspm_pkg::ThreshW-1:0]   cfg_wdata_i,
  vspm_req_if.sink                       req_i,
  vspm_rsp_if.source                     rsp_o
);
  import vspm_pkg::*;

  cfg_t cfg_q;
  req_t req_q;
  logic req_vld_q;
  rsp_t rsp_d, rsp_q;
  logic rsp_vld_q;
  logic advance;

  assign advance     = req_vld_q && (!rsp_vld_q || rsp_o.ready);
  assign req_i.ready = !req_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold <= ThreshReset;
      cfg_q.ticks     <= TicksReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_THRESHOLD: cfg_q.threshold <= cfg_wdata_i;
        CFG_TICKS:     cfg_q.ticks     <= cfg_wdata_i[TicksW-1:0];
        default: ;
      endcase
    end
  end

  // Hold the request until the state stage takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else if (req_i.valid && req_i.ready) begin
      req_vld_q <= 1'b1;
    end else if (advance) begin
      req_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      req_q.mode           <= req_i.mode;
      req_q.source_index   <= req_i.source_index;
      req_q.sample_voltage <= req_i.sample_voltage;
    end
  end

  vspm_state #(
    .NUM_SOURCES(NUM_SOURCES)
  ) u_vspm_state (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .commit_i(advance),
    .req_i   (req_q),
    .cfg_i   (cfg_q),
    .rsp_o   (rsp_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q <= 1'b0;
    end else if (advance) begin
      rsp_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid           = rsp_vld_q;
  assign rsp_o.fault_latched   = rsp_q.fault_latched;
  assign rsp_o.fault_event     = rsp_q.fault_event;
  assign rsp_o.spread_value    = rsp_q.spread_value;
  assign rsp_o.timer_running   = rsp_q.timer_running;
  assign rsp_o.monitor_running = rsp_q.monitor_running;
  assign rsp_o.seen_count      = rsp_q.seen_count;

endmodule

[rtl/core/vspm_checker.sv]
// Port-level checks of the monitor status stream, bound to the top level.
`include "assert_macros.svh"

module vspm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic                          fault_latched_i,
  input logic [vspm_pkg::EventW-1:0]   fault_event_i,
  input logic [vspm_pkg::VoltW-1:0]    spread_value_i,
  input logic                          timer_running_i,
  input logic                          monitor_running_i,
  input logic [vspm_pkg::SeenW-1:0]    seen_count_i
);
  import vspm_pkg::*;

  logic                               ev_seen;
  logic                               fault_quiet;
  logic                               halted;
  logic                               spread_nz;
  logic                               bad_code;
  logic                               stalled;
  logic [EventW+VoltW+SeenW+2:0]      rsp_bits;

  assign ev_seen     = rsp_valid_i && (fault_event_i != EV_NONE);
  assign fault_quiet = fault_latched_i && !monitor_running_i && !timer_running_i;
  assign halted      = rsp_valid_i && (fault_latched_i || !monitor_running_i);
  assign spread_nz   = rsp_valid_i && (spread_value_i != '0);
  assign bad_code    = rsp_valid_i && !(fault_event_i == EV_NONE ||
                                        fault_event_i == EV_IMMEDIATE ||
                                        fault_event_i == EV_TIMER);
  assign stalled     = rsp_valid_i && !rsp_ready_i;
  assign rsp_bits    = {fault_latched_i, fault_event_i, spread_value_i, timer_running_i,
                        monitor_running_i, seen_count_i};

  `VSPM_ASSERT(a_event_latches, clk_i, rst_ni, ev_seen |-> fault_quiet)
  `VSPM_ASSERT(a_latch_stops, clk_i, rst_ni, halted |-> !timer_running_i)
  `VSPM_ASSERT(a_spread_needs_two, clk_i, rst_ni, spread_nz |-> seen_count_i >= SeenW'(MinSeen))
  `VSPM_ASSERT_NEVER(a_event_code, clk_i, rst_ni, bad_code)
  `VSPM_ASSERT(a_stall_hold, clk_i, rst_ni, stalled |=> rsp_valid_i && $stable(rsp_bits))

endmodule

bind voltage_spread_plausibility_monitor vspm_checker u_vspm_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .fault_latched_i  (rsp_o.fault_latched),
  .fault_event_i    (rsp_o.fault_event),
  .spread_value_i   (rsp_o.spread_value),
  .timer_running_i  (rsp_o.timer_running),
  .monitor_running_i(rsp_o.monitor_running),
  .seen_count_i     (rsp_o.seen_count)
);
